// ----- design/iptk_pkg.sv -----
// Shared types, constants and command codes of the instruction profile counters.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package iptk_pkg;

    localparam int DEF_NUM_CLASSES = 48;
    localparam int DEF_TOP_K       = 10;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [2:0] FUNC_COUNT  = 3'd0;
    localparam logic [2:0] FUNC_BRANCH = 3'd1;
    localparam logic [2:0] FUNC_CYCLE  = 3'd2;
    localparam logic [2:0] FUNC_JUMP   = 3'd3;
    localparam logic [2:0] FUNC_JALR   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;
    localparam logic [2:0] FUNC_REPORT = 3'd6;

    typedef enum logic [2:0] {
        K_COUNT,
        K_BRANCH,
        K_CYCLE,
        K_FWD,
        K_BWD,
        K_CLEAR,
        K_REPORT,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] idx;
        logic       idx_ok;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  rank;
        logic [5:0]  opcode;
        logic [31:0] count;
        logic [37:0] tinstr;
        logic [63:0] cycles;
        logic [63:0] branches;
        logic [63:0] fwd;
        logic [63:0] bwd;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_bstate;

endpackage

// ----- design/iptk_front.sv -----
// Front end: decodes an incoming transaction into a command for the counter engine.
// Resolves jump direction and opcode range; depends on iptk_pkg.
`timescale 1ns / 1ps

module iptk_front
    import iptk_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [5:0]  i_opcode_index,
    input  logic [31:0] i_jump_offset,
    input  logic [31:0] i_pc_before,
    input  logic [31:0] i_pc_after,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_cmd        o_cmd
);

    logic [31:0] jalr_off;
    logic        jump_fwd;
    logic        jalr_fwd;

    assign jalr_off = i_pc_after - i_pc_before;
    assign jump_fwd = (i_jump_offset != 32'd0) && !i_jump_offset[31];
    assign jalr_fwd = (jalr_off != 32'd0) && !jalr_off[31];

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;

    always_comb begin
        o_cmd.idx    = i_opcode_index;
        o_cmd.idx_ok = {1'b0, i_opcode_index} < 7'(NUM_CLASSES);
        unique case (i_func)
            FUNC_COUNT:  o_cmd.kind = K_COUNT;
            FUNC_BRANCH: o_cmd.kind = K_BRANCH;
            FUNC_CYCLE:  o_cmd.kind = K_CYCLE;
            FUNC_JUMP:   o_cmd.kind = jump_fwd ? K_FWD : K_BWD;
            FUNC_JALR:   o_cmd.kind = jalr_fwd ? K_FWD : K_BWD;
            FUNC_CLEAR:  o_cmd.kind = K_CLEAR;
            FUNC_REPORT: o_cmd.kind = K_REPORT;
            default:     o_cmd.kind = K_NOP;
        endcase
    end

endmodule

// ----- design/iptk_fifo.sv -----
// Short command queue between the decoder and the counter engine.
// Holds decoded commands; depends on iptk_pkg.
`timescale 1ns / 1ps

module iptk_fifo
    import iptk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_cmd o_pop_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;

    assign o_push_ready = r_cnt != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign o_pop_cmd    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ----- design/iptk_back.sv -----
// Counter engine: opcode histogram memory, event totals and the top-K report scan.
// Drives the result register; depends on iptk_pkg.
`timescale 1ns / 1ps

module iptk_back
    import iptk_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int TOP_K       = DEF_TOP_K,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    localparam int              CLS_W     = $clog2(NUM_CLASSES);
    localparam int              NUM_RANK  = (TOP_K < NUM_CLASSES) ? TOP_K : NUM_CLASSES;
    localparam logic [3:0]      LAST_RANK = 4'(NUM_RANK - 1);
    localparam logic [CLS_W-1:0] LAST_IDX = CLS_W'(NUM_CLASSES - 1);

    logic [COUNT_WIDTH-1:0] r_mem [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    t_bstate                r_state, n_state;
    logic [63:0]            r_cycles, n_cycles;
    logic [63:0]            r_branches, n_branches;
    logic [63:0]            r_fwd, n_fwd;
    logic [63:0]            r_bwd, n_bwd;
    logic [37:0]            r_tinstr, n_tinstr;
    logic [NUM_CLASSES-1:0] r_vld, n_vld;
    logic [NUM_CLASSES-1:0] r_used, n_used;
    logic [CLS_W-1:0]       r_upd_idx, n_upd_idx;
    logic [CLS_W-1:0]       r_scan_idx, n_scan_idx;
    logic                   r_cmp_valid, n_cmp_valid;
    logic [CLS_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic                   r_best_found, n_best_found;
    logic [CLS_W-1:0]       r_best_idx, n_best_idx;
    logic [COUNT_WIDTH-1:0] r_best_val, n_best_val;
    logic [3:0]             r_rank, n_rank;
    logic                   r_out_valid;
    t_result                r_out, n_out;

    logic [CLS_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] cur_val;
    logic                   cmp_take;
    logic                   slot_free;
    logic                   out_load;
    logic                   report;
    logic                   mem_we;
    logic [63:0]            best_wide;

    assign rd_addr   = (r_state == ST_SCAN) ? r_scan_idx : i_cmd.idx[CLS_W-1:0];
    assign cur_val   = r_rd_vld ? r_rd_data : '0;
    assign cmp_take  = r_cmp_valid && !r_used[r_cmp_idx]
                       && (!r_best_found || (cur_val > r_best_val));
    assign slot_free = !r_out_valid || i_out_ready;
    assign best_wide = 64'(r_best_val);

    always_comb begin
        n_state      = r_state;
        n_cycles     = r_cycles;
        n_branches   = r_branches;
        n_fwd        = r_fwd;
        n_bwd        = r_bwd;
        n_tinstr     = r_tinstr;
        n_vld        = r_vld;
        n_used       = r_used;
        n_upd_idx    = r_upd_idx;
        n_scan_idx   = r_scan_idx;
        n_cmp_valid  = (r_state == ST_SCAN);
        n_cmp_idx    = r_scan_idx;
        n_best_found = r_best_found || cmp_take;
        n_best_idx   = cmp_take ? r_cmp_idx : r_best_idx;
        n_best_val   = cmp_take ? cur_val : r_best_val;
        n_rank       = r_rank;
        o_pop        = 1'b0;
        out_load     = 1'b0;
        report       = 1'b0;
        mem_we       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_COUNT: begin
                            if (i_cmd.idx_ok) begin
                                n_upd_idx = i_cmd.idx[CLS_W-1:0];
                                n_state   = ST_UPD;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        K_BRANCH: begin
                            n_branches = r_branches + 64'd1;
                            out_load   = 1'b1;
                        end
                        K_CYCLE: begin
                            n_cycles = r_cycles + 64'd1;
                            out_load = 1'b1;
                        end
                        K_FWD: begin
                            n_fwd    = r_fwd + 64'd1;
                            out_load = 1'b1;
                        end
                        K_BWD: begin
                            n_bwd    = r_bwd + 64'd1;
                            out_load = 1'b1;
                        end
                        K_CLEAR: begin
                            n_vld    = '0;
                            n_tinstr = '0;
                            out_load = 1'b1;
                        end
                        K_REPORT: begin
                            n_rank       = '0;
                            n_scan_idx   = '0;
                            n_used       = '0;
                            n_best_found = 1'b0;
                            n_state      = ST_SCAN;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_UPD: begin
                if (!(&cur_val)) begin
                    mem_we           = 1'b1;
                    n_vld[r_upd_idx] = 1'b1;
                    n_tinstr         = r_tinstr + 38'd1;
                end
                out_load = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (r_scan_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load           = 1'b1;
                    report             = 1'b1;
                    n_used[r_best_idx] = 1'b1;
                    if (r_rank == LAST_RANK) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rank       = r_rank + 4'd1;
                        n_scan_idx   = '0;
                        n_best_found = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out.rank     = report ? r_rank : 4'd0;
        n_out.opcode   = report ? 6'(r_best_idx) : 6'd0;
        n_out.count    = report ? best_wide[31:0] : 32'd0;
        n_out.tinstr   = n_tinstr;
        n_out.cycles   = n_cycles;
        n_out.branches = n_branches;
        n_out.fwd      = n_fwd;
        n_out.bwd      = n_bwd;
        n_out.last     = report ? (r_rank == LAST_RANK) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cycles     <= '0;
            r_branches   <= '0;
            r_fwd        <= '0;
            r_bwd        <= '0;
            r_tinstr     <= '0;
            r_vld        <= '0;
            r_used       <= '0;
            r_scan_idx   <= '0;
            r_cmp_valid  <= 1'b0;
            r_best_found <= 1'b0;
            r_rank       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cycles     <= n_cycles;
            r_branches   <= n_branches;
            r_fwd        <= n_fwd;
            r_bwd        <= n_bwd;
            r_tinstr     <= n_tinstr;
            r_vld        <= n_vld;
            r_used       <= n_used;
            r_scan_idx   <= n_scan_idx;
            r_cmp_valid  <= n_cmp_valid;
            r_best_found <= n_best_found;
            r_rank       <= n_rank;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd_idx  <= n_upd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_rd_vld   <= r_vld[rd_addr];
        r_rd_data  <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[r_upd_idx] <= cur_val + 1'b1;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- design/instruction_profile_counters_top_k_core.sv -----
// Top level of the instruction profile counters with top-K report.
// Instantiates iptk_front, iptk_fifo and iptk_back; depends on iptk_pkg.
//
// Usage: each input transaction carries one profiling event in s_axis_tuser
// (count opcode, branch, cycle, jump offset, jalr jump, clear histogram,
// report) with its operands in s_axis_tdata. Each event yields one output
// transaction with the updated totals; a report yields min(TOP_K, NUM_CLASSES)
// transactions, largest count first, ties to the lower opcode, and tlast on
// the final one. Non-report results carry zero rank, opcode and count.
// Results are registered: an event passes through the command queue and the
// output register, and a counted opcode also through an update state that
// reads and then writes the histogram memory. The engine takes one event per
// cycle for totals and clear while the output is ready; an opcode count holds
// it in the update state before it takes the next event. A report walks the
// memory through its single read port once per rank.
// Decoded commands wait in a four-entry queue, so input stays ready for up
// to four more transactions while the output waits. A stalled output holds
// its data; the engine waits before it loads the next result.
// Reset clears all counters and totals at once and leaves no output pending.
`timescale 1ns / 1ps

module instruction_profile_counters_top_k_core
    import iptk_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int TOP_K       = DEF_TOP_K,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode_index[5:0], jump_offset[37:6], pc_before[69:38], pc_after[101:70], zero pad
    input  logic [103:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rank[3:0], ranked_opcode[9:4], ranked_count[41:10], total_instructions[79:42],
    // total_cycles[143:80], total_branches[207:144], total_forward[271:208],
    // total_backward[335:272]
    output logic [335:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int         NUM_RANK  = (TOP_K < NUM_CLASSES) ? TOP_K : NUM_CLASSES;
    localparam logic [3:0] LAST_RANK = 4'(NUM_RANK - 1);

    logic    push_valid;
    logic    push_ready;
    t_cmd    push_cmd;
    logic    q_valid;
    logic    pop;
    t_cmd    q_cmd;
    t_result res;

    iptk_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser),
        .i_opcode_index (s_axis_tdata[5:0]),
        .i_jump_offset  (s_axis_tdata[37:6]),
        .i_pc_before    (s_axis_tdata[69:38]),
        .i_pc_after     (s_axis_tdata[101:70]),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_cmd          (push_cmd)
    );

    iptk_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (pop),
        .o_pop_cmd    (q_cmd)
    );

    iptk_back #(
        .NUM_CLASSES(NUM_CLASSES),
        .TOP_K      (TOP_K),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tdata = {res.bwd, res.fwd, res.branches, res.cycles,
                           res.tinstr, res.count, res.opcode, res.rank};
    assign m_axis_tlast = res.last;

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("Command queue popped while empty.");

    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (res.rank == 4'd0) || (res.rank == LAST_RANK))
        else $error("Final transaction carries an inner rank.");

    a_rank_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.rank != 4'd0) |-> {1'b0, res.opcode} < 7'(NUM_CLASSES))
        else $error("Reported opcode lies outside the histogram.");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the instruction profile counters with top-K report.
// Drives profiling events over the input stream and checks every output row against
// a scoreboard that predicts the histogram and totals; depends on iptk_pkg and the core.
`timescale 1ns / 1ps

module testbench;
    import iptk_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    typedef struct {
        logic [3:0]  rank;
        logic [5:0]  opcode;
        logic [31:0] count;
        logic [37:0] instr_total;
        logic [63:0] cycles;
        logic [63:0] branches;
        logic [63:0] fwd_jumps;
        logic [63:0] bwd_jumps;
        logic        last;
    } profile_row_t;

    class profile_scoreboard;
        logic [DEF_COUNT_WIDTH-1:0] class_count[DEF_NUM_CLASSES];
        logic [63:0] cycles;
        logic [63:0] branches;
        logic [63:0] fwd_jumps;
        logic [63:0] bwd_jumps;
        profile_row_t pending_rows[$];
        int errors;

        function new();
            foreach (class_count[i]) class_count[i] = '0;
            cycles    = '0;
            branches  = '0;
            fwd_jumps = '0;
            bwd_jumps = '0;
            errors    = 0;
        endfunction

        function int pending();
            return pending_rows.size();
        endfunction

        function void tally_jump(logic [31:0] distance);
            if (distance != 32'd0 && !distance[31]) begin
                fwd_jumps++;
            end else begin
                bwd_jumps++;
            end
        endfunction

        function void push_row(int rank, int opcode, logic [31:0] count, bit last);
            profile_row_t row;
            logic [37:0]  sum;
            sum = '0;
            foreach (class_count[i]) sum += 38'(class_count[i]);
            row.rank        = 4'(rank);
            row.opcode      = 6'(opcode);
            row.count       = count;
            row.instr_total = sum;
            row.cycles      = cycles;
            row.branches    = branches;
            row.fwd_jumps   = fwd_jumps;
            row.bwd_jumps   = bwd_jumps;
            row.last        = last;
            pending_rows.push_back(row);
        endfunction

        // Applies one accepted event and queues the rows it must produce.
        function void apply_event(logic [2:0] func, logic [5:0] op, logic [31:0] offset,
                                  logic [31:0] pc_before, logic [31:0] pc_after);
            logic [DEF_NUM_CLASSES-1:0] listed;
            int best;
            int ranks;
            int k;
            int i;
            case (func)
                FUNC_COUNT: begin
                    if (op < DEF_NUM_CLASSES && class_count[op] != '1) class_count[op]++;
                end
                FUNC_BRANCH: branches++;
                FUNC_CYCLE:  cycles++;
                FUNC_JUMP:   tally_jump(offset);
                FUNC_JALR:   tally_jump(pc_after - pc_before);
                FUNC_CLEAR: begin
                    foreach (class_count[j]) class_count[j] = '0;
                end
                FUNC_REPORT: begin
                    ranks  = (DEF_TOP_K < DEF_NUM_CLASSES) ? DEF_TOP_K : DEF_NUM_CLASSES;
                    listed = '0;
                    for (k = 0; k < ranks; k++) begin
                        best = -1;
                        for (i = 0; i < DEF_NUM_CLASSES; i++) begin
                            if (!listed[i] && (best < 0 || class_count[i] > class_count[best]))
                                best = i;
                        end
                        listed[best] = 1'b1;
                        push_row(k, best, 32'(class_count[best]), k == ranks - 1);
                    end
                    return;
                end
                default: ;
            endcase
            push_row(0, 0, 32'd0, 1'b1);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_row(logic [335:0] data, logic last);
            profile_row_t want;
            if (pending_rows.size() == 0) begin
                $error("output transaction with no expected result pending");
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            compare_field("rank",               want.rank,        data[3:0]);
            compare_field("ranked_opcode",      want.opcode,      data[9:4]);
            compare_field("ranked_count",       want.count,       data[41:10]);
            compare_field("total_instructions", want.instr_total, data[79:42]);
            compare_field("total_cycles",       want.cycles,      data[143:80]);
            compare_field("total_branches",     want.branches,    data[207:144]);
            compare_field("total_forward",      want.fwd_jumps,   data[271:208]);
            compare_field("total_backward",     want.bwd_jumps,   data[335:272]);
            compare_field("last",               want.last,        last);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [335:0] m_axis_tdata;
    logic         m_axis_tlast;

    profile_scoreboard board = new();
    int sent_items = 0;
    int rows_taken = 0;
    int hold_left = 0;
    int hold_draw;

    instruction_profile_counters_top_k_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_distance();
        logic [31:0] corners[5] = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 3))
            0:       return corners[$urandom_range(0, 4)];
            1:       return 32'($signed($urandom_range(0, 32)) - 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [2:0] func, logic [5:0] op, logic [31:0] offset,
                             logic [31:0] pc_before, logic [31:0] pc_after);
        int gap;
        gap = draw_gap(((sent_items / 25) % 3) == 1);
        sent_items++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, pc_after, pc_before, offset, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.apply_event(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
                              s_axis_tdata[69:38], s_axis_tdata[101:70]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            board.check_row(m_axis_tdata, m_axis_tlast);
            rows_taken <= rows_taken + 1;
            hold_draw = draw_gap(((rows_taken / 30) % 3) == 1);
            if (hold_draw != 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_draw - 1;
            end
        end else if (!m_axis_tready) begin
            if (hold_left == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end
    end

    initial begin
        int          n;
        int          pick;
        int          spin;
        logic [2:0]  func;
        logic [5:0]  op;
        logic [31:0] base;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events: table corners, jump sign boundaries and wrapped jalr distances.
        send_item(FUNC_REPORT, 6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_COUNT,  6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_COUNT,  6'd47, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_COUNT,  6'd48, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_COUNT,  6'd63, '1, '1, '1);
        send_item(FUNC_COUNT,  6'd47, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_COUNT,  6'd5, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_BRANCH, 6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_CYCLE,  6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_JUMP,   6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_JUMP,   6'd0, 32'd1, 32'd0, 32'd0);
        send_item(FUNC_JUMP,   6'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_item(FUNC_JUMP,   6'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_item(FUNC_JUMP,   6'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(FUNC_JALR,   6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(FUNC_JALR,   6'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(FUNC_JALR,   6'd0, 32'd0, 32'h1234_5678, 32'h1234_5678);
        send_item(FUNC_UNUSED, 6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_REPORT, 6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_CLEAR,  6'd0, 32'd0, 32'd0, 32'd0);
        send_item(FUNC_REPORT, 6'd0, 32'd0, 32'd0, 32'd0);

        // Random events, with counts the most frequent kind and mostly on a few hot classes so the ranking has ties.
        for (n = 0; n < 259; n++) begin
            pick = $urandom_range(0, 99);
            op   = 6'($urandom);
            base = $urandom;
            if (pick < 45) begin
                func = FUNC_COUNT;
                case ($urandom_range(0, 9))
                    0:       op = 6'($urandom_range(48, 63));
                    1, 2:    op = 6'($urandom_range(0, 47));
                    default: op = 6'($urandom_range(0, 11));
                endcase
            end else if (pick < 55) begin
                func = FUNC_BRANCH;
            end else if (pick < 65) begin
                func = FUNC_CYCLE;
            end else if (pick < 75) begin
                func = FUNC_JUMP;
            end else if (pick < 85) begin
                func = FUNC_JALR;
            end else if (pick < 88) begin
                func = FUNC_CLEAR;
            end else if (pick < 94) begin
                func = FUNC_REPORT;
            end else begin
                func = FUNC_UNUSED;
            end
            send_item(func, op, pick_distance(), base, base + pick_distance());
        end
        s_axis_tvalid <= 1'b0;

        spin = 0;
        while (board.pending() != 0 && spin < 100000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (20) @(posedge i_clk);
        if (board.pending() != 0)
            $error("%0d expected results never arrived", board.pending());
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
design/iptk_pkg.sv
design/iptk_front.sv
design/iptk_fifo.sv
design/iptk_back.sv
design/instruction_profile_counters_top_k_core.sv
tb/sv/testbench.sv
